[sv/wgtg_pkg.sv]
// wgtg_pkg: shared types, constants and the micro-program for the waypoint follower
// used by wgtg_seq and waypoint_go_to_goal_controller; no dependencies
`default_nettype none

package wgtg_pkg;

  localparam int ADDR_W      = 5;
  localparam int UPC_W       = 3;
  localparam int ITER_W      = 5;
  localparam int SQRT_STEPS  = 17;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WP_ZERO    = 3'd0;
  localparam logic [2:0] REG_WP_FOUR    = 3'd4;
  localparam logic [2:0] REG_WP_COUNT   = 3'd5;
  localparam logic [2:0] REG_HEAD_TOL   = 3'd6;
  localparam logic [2:0] REG_ARRIVE_RAD = 3'd7;

  typedef enum logic [2:0] {
    UOP_DIFF,
    UOP_SQX,
    UOP_SQY,
    UOP_INIT,
    UOP_ITER,
    UOP_ROUND,
    UOP_WRAP,
    UOP_DECIDE
  } uop_t;

  typedef struct packed {
    uop_t             op;
    logic             jmp;
    logic [UPC_W-1:0] tgt;
    logic             last;
  } uword_t;

  typedef struct packed {
    logic              busy;
    uop_t              op;
    logic [ITER_W-1:0] iter;
  } ctrl_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      3'd0:    w = '{op: UOP_DIFF,   jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd1:    w = '{op: UOP_SQX,    jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd2:    w = '{op: UOP_SQY,    jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd3:    w = '{op: UOP_INIT,   jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd4:    w = '{op: UOP_ITER,   jmp: 1'b1, tgt: 3'd4, last: 1'b0};
      3'd5:    w = '{op: UOP_ROUND,  jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd6:    w = '{op: UOP_WRAP,   jmp: 1'b0, tgt: 3'd0, last: 1'b0};
      3'd7:    w = '{op: UOP_DECIDE, jmp: 1'b0, tgt: 3'd0, last: 1'b1};
      default: w = '{op: UOP_DECIDE, jmp: 1'b0, tgt: 3'd0, last: 1'b1};
    endcase
    return w;
  endfunction

  // atan(2^-i) in Q.24, rounded
  function automatic logic [23:0] atan_q24(input logic [ITER_W-1:0] i);
    logic [23:0] a;
    case (i)
      5'd0:    a = 24'd13176795;
      5'd1:    a = 24'd7778716;
      5'd2:    a = 24'd4110060;
      5'd3:    a = 24'd2086331;
      5'd4:    a = 24'd1047214;
      5'd5:    a = 24'd524117;
      5'd6:    a = 24'd262123;
      5'd7:    a = 24'd131069;
      5'd8:    a = 24'd65536;
      5'd9:    a = 24'd32768;
      5'd10:   a = 24'd16384;
      5'd11:   a = 24'd8192;
      5'd12:   a = 24'd4096;
      5'd13:   a = 24'd2048;
      5'd14:   a = 24'd1024;
      5'd15:   a = 24'd512;
      5'd16:   a = 24'd256;
      5'd17:   a = 24'd128;
      5'd18:   a = 24'd64;
      5'd19:   a = 24'd32;
      5'd20:   a = 24'd16;
      5'd21:   a = 24'd8;
      5'd22:   a = 24'd4;
      5'd23:   a = 24'd2;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[sv/wgtg_seq.sv]
// wgtg_seq: micro-program sequencer, step counter with a loop counter and conditional jump
// depends on wgtg_pkg (ucode table, ctrl_t)
`default_nettype none

module wgtg_seq #(
  parameter int LOOP_N = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           hold,
  output wgtg_pkg::ctrl_t     ctrl
);

  logic                               busy_r, busy_nxt;
  logic [wgtg_pkg::UPC_W-1:0]         upc_r, upc_nxt;
  logic [wgtg_pkg::ITER_W-1:0]        iter_r, iter_nxt;
  wgtg_pkg::uword_t                   uw;
  logic                               loop_done;

  always_comb begin
    uw        = wgtg_pkg::ucode(upc_r);
    loop_done = (iter_r == wgtg_pkg::ITER_W'(LOOP_N - 1));
    busy_nxt  = busy_r;
    upc_nxt   = upc_r;
    iter_nxt  = iter_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = '0;
      iter_nxt = '0;
    end else if (busy_r && !hold) begin
      if (uw.last) begin
        busy_nxt = 1'b0;
      end else if (uw.jmp && !loop_done) begin
        upc_nxt  = uw.tgt;
        iter_nxt = iter_r + 1'b1;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      iter_r <= iter_nxt;
    end
  end

  assign ctrl.busy = busy_r;
  assign ctrl.op   = uw.op;
  assign ctrl.iter = iter_r;

endmodule

`default_nettype wire

[sv/waypoint_go_to_goal_controller.sv]
// Proportional go-to-goal waypoint follower, top level.
// Pose items enter on in_* (valid/stall), commands leave on out_* (valid/stall), and
// the route, tolerance and radius are set over an APB-style register port (pready tied high).
// Each accepted pose is taken apart by a micro-programmed datapath: the vector to the
// current waypoint, its length by a digit-by-digit square root and its bearing by a
// vectoring CORDIC, both stepped by one shared loop of max(17, CORDIC_STEPS) iterations.
// The steps run in order: difference, two squares, init, the shared loop, round, wrap and
// decide, which registers the result; the sequencer holds in_stall high meanwhile, so the
// next pose is taken only once the previous one has finished all its steps.
// The result sits in an output register, so the next pose starts while it waits; if it
// is still stalled when the next result is ready, the sequencer holds on its last step.
// Once the route is done, poses are taken but give no result until reset or a higher count.
// Reset (synchronous, rst_n low) restores the register defaults and targets waypoint 0.
// The user must write registers only while the block is idle; the block does not enforce it.
`default_nettype none

module waypoint_go_to_goal_controller #(
  parameter int MAX_WAYPOINTS = 5,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // pose channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [15:0]                   in_pose_x,
  input  wire logic [15:0]                   in_pose_y,
  input  wire logic signed [15:0]            in_pose_heading,
  // command channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [17:0]                        out_linear_speed,
  output logic signed [15:0]                 out_angular_rate,
  output logic                               out_arrived,
  output logic                               out_pen_on_pulse,
  output logic                               out_route_done,
  output logic [2:0]                         out_target_index,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wgtg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int LOOP_N = (CORDIC_STEPS > wgtg_pkg::SQRT_STEPS) ?
                          CORDIC_STEPS : wgtg_pkg::SQRT_STEPS;

  // ---------------- configuration registers ----------------
  logic [31:0] wp_r [MAX_WAYPOINTS];
  logic [2:0]  wcount_r;
  logic [14:0] tol_r;
  logic [15:0] radius_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wgtg_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_WAYPOINTS; k++) wp_r[k] <= '0;
      wcount_r <= 3'd5;
      tol_r    <= 15'd164;
      radius_r <= 16'd410;
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        [wgtg_pkg::REG_WP_ZERO:wgtg_pkg::REG_WP_FOUR]: begin
          for (int k = 0; k < MAX_WAYPOINTS; k++) begin
            if (reg_idx == 3'(k)) wp_r[k] <= pwdata;
          end
        end
        wgtg_pkg::REG_WP_COUNT:   wcount_r <= pwdata[2:0];
        wgtg_pkg::REG_HEAD_TOL:   tol_r    <= pwdata[14:0];
        wgtg_pkg::REG_ARRIVE_RAD: radius_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx) inside
      [wgtg_pkg::REG_WP_ZERO:wgtg_pkg::REG_WP_FOUR]: begin
        for (int k = 0; k < MAX_WAYPOINTS; k++) begin
          if (reg_idx == 3'(k)) prdata = wp_r[k];
        end
      end
      wgtg_pkg::REG_WP_COUNT:   prdata = {29'd0, wcount_r};
      wgtg_pkg::REG_HEAD_TOL:   prdata = {17'd0, tol_r};
      wgtg_pkg::REG_ARRIVE_RAD: prdata = {16'd0, radius_r};
      default:                  prdata = '0;
    endcase
  end

  // count clamped to 1..MAX_WAYPOINTS
  logic [2:0] eff_count;
  always_comb begin
    if (wcount_r == 3'd0)                     eff_count = 3'd1;
    else if (wcount_r > 3'(MAX_WAYPOINTS))    eff_count = 3'(MAX_WAYPOINTS);
    else                                      eff_count = wcount_r;
  end

  // ---------------- sequencer ----------------
  wgtg_pkg::ctrl_t ctrl;
  logic            start, hold, step_en, in_xfer, route_end, out_valid_r;
  logic [2:0]      idx_r;

  assign in_stall  = ctrl.busy;
  assign in_xfer   = in_valid && !in_stall;
  assign route_end = (idx_r >= eff_count);
  assign start     = in_xfer && !route_end;
  assign hold      = (ctrl.op == wgtg_pkg::UOP_DECIDE) && out_valid_r && out_stall;
  assign step_en   = ctrl.busy && !hold;

  wgtg_seq #(
    .LOOP_N (LOOP_N)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .ctrl  (ctrl)
  );

  // ---------------- datapath ----------------
  logic [15:0]         px_r, py_r;
  logic signed [15:0]  head_r;
  logic signed [16:0]  dx_r, dy_r;
  logic [33:0]         acc_r;
  logic [33:0]         rem_r, res_r, bit_r;
  logic signed [27:0]  x_r, y_r, z_r;
  logic                zero_r;
  logic signed [17:0]  err_r;

  logic [31:0]         wp_sel;
  logic signed [16:0]  dx_c, dy_c, mul_a;
  logic signed [33:0]  sq;
  logic [34:0]         trial;
  logic signed [27:0]  xs, ys, x0, y0, atan_v, zt;
  logic signed [16:0]  brg;
  logic signed [17:0]  err_c, err_w;
  logic [16:0]         aerr, goal_dist;
  logic                turn, drive;

  always_comb begin
    wp_sel = '0;
    for (int k = 0; k < MAX_WAYPOINTS; k++) begin
      if (idx_r == 3'(k)) wp_sel = wp_r[k];
    end
  end

  assign dx_c  = $signed({1'b0, wp_sel[31:16]}) - $signed({1'b0, px_r});
  assign dy_c  = $signed({1'b0, wp_sel[15:0]}) - $signed({1'b0, py_r});
  assign mul_a = (ctrl.op == wgtg_pkg::UOP_SQX) ? dx_r : dy_r;
  assign sq    = mul_a * mul_a;

  // square root trial subtract
  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  // cordic micro-rotation terms
  assign xs     = x_r >>> ctrl.iter;
  assign ys     = y_r >>> ctrl.iter;
  assign atan_v = $signed({4'd0, wgtg_pkg::atan_q24(ctrl.iter)});
  assign x0     = 28'(dx_r) <<< 8;
  assign y0     = 28'(dy_r) <<< 8;

  // round Q.24 angle to Q3.13
  assign zt    = z_r + 28'sd1024;
  assign brg   = zero_r ? 17'sd0 : zt[27:11];
  assign err_c = 18'(brg) - 18'(head_r);

  always_comb begin
    if (err_r > wgtg_pkg::PI_Q13)       err_w = err_r - wgtg_pkg::TWO_PI_Q13;
    else if (err_r <= -wgtg_pkg::PI_Q13) err_w = err_r + wgtg_pkg::TWO_PI_Q13;
    else                                 err_w = err_r;
  end

  assign aerr      = err_r[17] ? 17'(-err_r) : err_r[16:0];
  assign goal_dist = res_r[16:0];
  assign turn      = aerr > {2'd0, tol_r};
  assign drive     = goal_dist > {1'b0, radius_r};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r   <= in_pose_x;
      py_r   <= in_pose_y;
      head_r <= in_pose_heading;
    end
    if (step_en) begin
      unique case (ctrl.op)
        wgtg_pkg::UOP_DIFF: begin
          dx_r <= dx_c;
          dy_r <= dy_c;
        end
        wgtg_pkg::UOP_SQX: acc_r <= sq[33:0];
        wgtg_pkg::UOP_SQY: acc_r <= acc_r + sq[33:0];
        wgtg_pkg::UOP_INIT: begin
          rem_r  <= acc_r;
          res_r  <= '0;
          bit_r  <= 34'd1 << 32;
          zero_r <= (dx_r == 17'sd0) && (dy_r == 17'sd0);
          if (dx_r < 0) begin
            if (dy_r >= 0) begin
              x_r <= y0;
              y_r <= -x0;
              z_r <= wgtg_pkg::HALF_PI_Q24;
            end else begin
              x_r <= -y0;
              y_r <= x0;
              z_r <= -wgtg_pkg::HALF_PI_Q24;
            end
          end else begin
            x_r <= x0;
            y_r <= y0;
            z_r <= '0;
          end
        end
        wgtg_pkg::UOP_ITER: begin
          if (ctrl.iter < wgtg_pkg::ITER_W'(wgtg_pkg::SQRT_STEPS)) begin
            if ({1'b0, rem_r} >= trial) begin
              rem_r <= rem_r - trial[33:0];
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
          if (ctrl.iter < wgtg_pkg::ITER_W'(CORDIC_STEPS)) begin
            if (y_r > 0) begin
              x_r <= x_r + ys;
              y_r <= y_r - xs;
              z_r <= z_r + atan_v;
            end else begin
              x_r <= x_r - ys;
              y_r <= y_r + xs;
              z_r <= z_r - atan_v;
            end
          end
        end
        wgtg_pkg::UOP_ROUND: err_r <= err_c;
        wgtg_pkg::UOP_WRAP:  err_r <= err_w;
        wgtg_pkg::UOP_DECIDE: begin
          out_target_index <= idx_r;
          out_linear_speed <= '0;
          out_angular_rate <= '0;
          out_arrived      <= 1'b0;
          out_pen_on_pulse <= 1'b0;
          out_route_done   <= 1'b0;
          if (turn) begin
            out_angular_rate <= err_r[15:0];
          end else if (drive) begin
            out_linear_speed <= {goal_dist, 1'b0};
          end else begin
            out_arrived      <= 1'b1;
            out_pen_on_pulse <= (idx_r == 3'd0);
            out_route_done   <= ((idx_r + 3'd1) == eff_count);
          end
        end
        default: ;
      endcase
    end
  end

  // control state: waypoint pointer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en && (ctrl.op == wgtg_pkg::UOP_DECIDE)) begin
        out_valid_r <= 1'b1;
        if (!turn && !drive) idx_r <= idx_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/wgtg_chk.sv]
// wgtg_chk: port-level checks on the command channel of the waypoint follower
// bound to waypoint_go_to_goal_controller below; no package dependencies
`default_nettype none

module wgtg_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [17:0]          out_linear_speed,
  input wire logic signed [15:0]   out_angular_rate,
  input wire logic                 out_arrived,
  input wire logic                 out_pen_on_pulse,
  input wire logic                 out_route_done,
  input wire logic [2:0]           out_target_index
);

  // a stalled transfer keeps its command
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_speed) &&
      $stable(out_angular_rate) && $stable(out_arrived) && $stable(out_target_index))
    else $error("command changed while stalled");

  // arrival commands no motion
  a_arrive_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_linear_speed == 18'd0 && out_angular_rate == 16'sd0)
    else $error("motion commanded on arrival");

  // pen and route flags only come with arrival
  a_flags_need_arrival: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_arrived |-> !out_pen_on_pulse && !out_route_done)
    else $error("pen or route flag without arrival");

  // pen pulse belongs to the first waypoint
  a_pen_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pen_on_pulse |-> out_target_index == 3'd0)
    else $error("pen pulse away from first waypoint");

  // never turn and drive at once
  a_turn_or_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_linear_speed != 18'd0 |-> out_angular_rate == 16'sd0)
    else $error("turn and drive commanded together");

endmodule

bind waypoint_go_to_goal_controller wgtg_chk u_wgtg_chk (.*);

`default_nettype wire

[test/waypoint_go_to_goal_controller_tb.sv]
// waypoint_go_to_goal_controller_tb: self-checking bench for the go-to-goal waypoint follower
// drives pose transfers in bursts, predicts each command in-bench and checks the command channel
// depends on wgtg_pkg and waypoint_go_to_goal_controller
module waypoint_go_to_goal_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_WP      = 5;
  localparam int     CORDIC_ITER = 16;
  localparam longint HALF_TURN   = 25736;
  localparam longint FULL_TURN   = 51472;
  localparam longint QUARTER_Q24 = 26353589;
  localparam int     PAD_CYCLES  = 40;
  localparam int     SETTLE_MAX  = 200000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic [17:0] speed;
    logic [15:0] rate;
    logic        arrived;
    logic        pen;
    logic        done;
    logic [2:0]  target;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_pose_x = '0;
  logic [15:0] in_pose_y = '0;
  logic signed [15:0] in_pose_heading = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [17:0] out_linear_speed;
  logic signed [15:0] out_angular_rate;
  logic        out_arrived;
  logic        out_pen_on_pulse;
  logic        out_route_done;
  logic [2:0]  out_target_index;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [wgtg_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // register image and route position as the block should hold them
  logic [31:0] wp_reg [0:4] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
  logic [2:0]  count_reg = 3'd5;
  logic [14:0] tol_reg = 15'd164;
  logic [15:0] rad_reg = 16'd410;
  logic [2:0]  route_pos = 3'd0;

  longint atan_tab [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  pose_t pending_poses [$];
  cmd_t  expected_cmds [$];

  int fails = 0;
  int poses_taken = 0;
  int cmds_seen = 0;
  int n_turn = 0;
  int n_drive = 0;
  int n_arrive = 0;

  waypoint_go_to_goal_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pose_x        (in_pose_x),
    .in_pose_y        (in_pose_y),
    .in_pose_heading  (in_pose_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_arrived      (out_arrived),
    .out_pen_on_pulse (out_pen_on_pulse),
    .out_route_done   (out_route_done),
    .out_target_index (out_target_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint vec_len(input longint sq);
    longint r;
    longint t;
    int b;
    r = 0;
    for (b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= sq) r = t;
    end
    return r;
  endfunction

  // vectoring cordic, angle in Q3.13
  function automatic longint goal_bearing(input longint dx, input longint dy);
    longint xv, yv, zv, xs, ys, t;
    int i;
    if (dx == 0 && dy == 0) return 0;
    xv = dx * 256;
    yv = dy * 256;
    zv = 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; zv = QUARTER_Q24;
      end else begin
        t = xv; xv = -yv; yv = t; zv = -QUARTER_Q24;
      end
    end
    for (i = 0; i < CORDIC_ITER && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; zv = zv + atan_tab[i];
      end else begin
        xv = xv - ys; yv = yv + xs; zv = zv - atan_tab[i];
      end
    end
    return (zv + 1024) >>> 11;
  endfunction

  // returns 0 when the route is over for this index
  function automatic bit steer_cmd(input pose_t p, input logic [2:0] at, output cmd_t c);
    longint dx, dy, goal_dist, err, mag;
    int span;
    c = '0;
    span = (count_reg == 3'd0) ? 1 : ((count_reg > MAX_WP) ? MAX_WP : int'(count_reg));
    if (int'(at) >= span) return 1'b0;
    dx = longint'(wp_reg[at][31:16]) - longint'(p.x);
    dy = longint'(wp_reg[at][15:0]) - longint'(p.y);
    goal_dist = vec_len(dx * dx + dy * dy);
    err = goal_bearing(dx, dy) - longint'($signed(p.heading));
    while (err > HALF_TURN) err = err - FULL_TURN;
    while (err <= -HALF_TURN) err = err + FULL_TURN;
    mag = (err < 0) ? -err : err;
    c.target = at;
    if (mag > longint'(tol_reg)) begin
      c.rate = err[15:0];
    end else if (goal_dist > longint'(rad_reg)) begin
      c.speed = 18'(goal_dist * 2);
    end else begin
      c.arrived = 1'b1;
      c.pen = (at == 3'd0);
      c.done = (int'(at) + 1 == span);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- pose driver

  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    cmd_t c;
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        if (steer_cmd(pending_poses[0], route_pos, c)) begin
          expected_cmds.push_back(c);
          if (c.arrived) route_pos = route_pos + 3'd1;
        end
        void'(pending_poses.pop_front());
        poses_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_poses.size() != 0) begin
          in_pose_x <= pending_poses[0].x;
          in_pose_y <= pending_poses[0].y;
          in_pose_heading <= pending_poses[0].heading;
          nv = 1'b1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 10);
              gap_left = $urandom_range(1, 60);
            end
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= nv;
    end
  end

  // ---------------------------------------------------------------- command monitor

  int  hold_left = 0;
  bit  held_once = 1'b0;
  int  stall_mode = 0;
  int  mode_left = 0;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fails++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cmd_t e;
    logic ns;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        cmds_seen++;
        if (expected_cmds.size() == 0) begin
          fails++;
          $display("%0t: command transfer with nothing expected (speed %0d rate %0d)",
                   $time, out_linear_speed, out_angular_rate);
        end else begin
          e = expected_cmds.pop_front();
          check_field("linear_speed", e.speed, out_linear_speed);
          check_field("angular_rate", $signed(e.rate), out_angular_rate);
          check_field("arrived", e.arrived, out_arrived);
          check_field("pen_on_pulse", e.pen, out_pen_on_pulse);
          check_field("route_done", e.done, out_route_done);
          check_field("target_index", e.target, out_target_index);
          if (e.arrived) n_arrive++;
          else if (e.rate != 16'd0) n_turn++;
          else n_drive++;
        end
      end
      // long hold once results flow, so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (!held_once && cmds_seen >= 100) begin
        held_once = 1'b1;
        hold_left = 400;
        ns = 1'b1;
      end else begin
        if ($urandom_range(0, 999) == 0) hold_left = $urandom_range(80, 300);
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: ns = 1'b0;
          1: ns = ($urandom_range(0, 3) == 0);
          default: ns = ($urandom_range(0, 4) != 0);
        endcase
      end
      out_stall <= ns;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= wgtg_pkg::REG_WP_FOUR) wp_reg[idx] = val;
    else if (idx == wgtg_pkg::REG_WP_COUNT) count_reg = val[2:0];
    else if (idx == wgtg_pkg::REG_HEAD_TOL) tol_reg = val[14:0];
    else if (idx == wgtg_pkg::REG_ARRIVE_RAD) rad_reg = val[15:0];
  endtask

  task automatic queue_pose(input int x, input int y, input int h);
    pose_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.heading = h[15:0];
    pending_poses.push_back(p);
  endtask

  // wait for every pose and command to go through, then let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    while ((pending_poses.size() != 0 || expected_cmds.size() != 0) && waited < SETTLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= SETTLE_MAX) begin
      fails++;
      $display("%0t: %0d commands never arrived", $time, expected_cmds.size());
      expected_cmds.delete();
    end
    repeat (PAD_CYCLES) @(posedge clk);
  endtask

  function automatic int clamp16(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // random poses that never reach the current waypoint, half of them pointed near it
  task automatic queue_random_poses(input int n);
    pose_t p;
    cmd_t c;
    int wx, wy, nx, ny, hv, pick, k;
    bit ok;
    wx = int'(wp_reg[route_pos][31:16]);
    wy = int'(wp_reg[route_pos][15:0]);
    for (k = 0; k < n; k++) begin
      ok = 1'b0;
      while (!ok) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          nx = $urandom_range(0, 1) ? 65535 : 0;
          ny = $urandom_range(0, 1) ? 65535 : 0;
        end else if (pick < 30) begin
          nx = clamp16(wx + int'($urandom_range(0, 600)) - 300);
          ny = clamp16(wy + int'($urandom_range(0, 600)) - 300);
        end else begin
          nx = $urandom_range(0, 65535);
          ny = $urandom_range(0, 65535);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          hv = int'(goal_bearing(wx - nx, wy - ny)) + int'($urandom_range(0, 2 * tol_reg + 4))
               - (int'(tol_reg) + 2);
          while (hv > HALF_TURN) hv = hv - int'(FULL_TURN);
          while (hv < -HALF_TURN) hv = hv + int'(FULL_TURN);
          // same direction, heading out of the normal range
          if ($urandom_range(0, 3) == 0) begin
            if (hv > 18705) hv = hv - int'(FULL_TURN);
            else if (hv < -18705) hv = hv + int'(FULL_TURN);
          end
        end else if (pick < 65) begin
          hv = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          hv = int'($urandom_range(0, 51472)) - 25736;
        end
        p.x = nx[15:0];
        p.y = ny[15:0];
        p.heading = hv[15:0];
        ok = !(steer_cmd(p, route_pos, c) && c.arrived);
      end
      pending_poses.push_back(p);
    end
  endtask

  initial begin
    int ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: five waypoints all at the origin, the first one reached there
    queue_pose(65535, 65535, 0);
    queue_pose(0, 65535, -25736);
    queue_pose(65535, 0, 25736);
    queue_pose(100, 0, 32767);
    queue_pose(0, 0, -32768);
    queue_pose(0, 0, 25736);
    queue_pose(0, 0, 0);
    settle();

    // count of zero clamps to one, which ends the route at index one
    write_reg(wgtg_pkg::REG_WP_ZERO, $urandom);
    write_reg(wgtg_pkg::REG_WP_ZERO + 3'd1, 32'h8000_8000);
    write_reg(wgtg_pkg::REG_WP_COUNT, 32'd0);
    queue_pose($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
    queue_pose(32768, 32768, 0);
    settle();

    // raising the count resumes, second waypoint finishes a two-point route
    write_reg(wgtg_pkg::REG_WP_COUNT, 32'd2);
    queue_pose(28672, 32768, 0);
    queue_pose(32768, 32778, -12868);
    queue_pose(4660, 17185, 0);
    settle();

    // count above the maximum clamps to five
    write_reg(wgtg_pkg::REG_WP_COUNT, 32'd7);
    write_reg(wgtg_pkg::REG_WP_ZERO + 3'd3, $urandom);
    write_reg(wgtg_pkg::REG_WP_FOUR, $urandom);
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(wgtg_pkg::REG_WP_ZERO + 3'd2, $urandom);
          write_reg(wgtg_pkg::REG_HEAD_TOL, 32'd164);
          write_reg(wgtg_pkg::REG_ARRIVE_RAD, 32'd0);
        end
        1: begin
          write_reg(wgtg_pkg::REG_WP_ZERO + 3'd2, 32'hFFFF_FFFF);
          write_reg(wgtg_pkg::REG_HEAD_TOL, 32'd0);
        end
        2: begin
          write_reg(wgtg_pkg::REG_WP_ZERO + 3'd2, 32'h0000_0000);
          write_reg(wgtg_pkg::REG_HEAD_TOL, 32'd25736);
          write_reg(wgtg_pkg::REG_ARRIVE_RAD, $urandom_range(1, 4000));
        end
        default: begin
          write_reg(wgtg_pkg::REG_WP_ZERO + 3'd2, $urandom);
          write_reg(wgtg_pkg::REG_HEAD_TOL, $urandom_range(0, 24000));
          write_reg(wgtg_pkg::REG_ARRIVE_RAD, 32'd65535);
        end
      endcase
      queue_random_poses(460);
      settle();
    end

    // widest tolerance and radius: walk the rest of the route, then nothing more comes
    write_reg(wgtg_pkg::REG_HEAD_TOL, 32'd25736);
    write_reg(wgtg_pkg::REG_ARRIVE_RAD, 32'd65535);
    queue_pose(wp_reg[2][31:16], wp_reg[2][15:0], $urandom_range(0, 65535));
    queue_pose(wp_reg[3][31:16], wp_reg[3][15:0], $urandom_range(0, 65535));
    queue_pose(wp_reg[4][31:16], wp_reg[4][15:0], $urandom_range(0, 65535));
    queue_pose($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
    queue_pose(0, 0, 0);
    queue_pose(65535, 65535, -32768);
    settle();

    $display("run covered %0d pose transfers and %0d commands: %0d turn, %0d drive, %0d arrival",
             poses_taken, cmds_seen, n_turn, n_drive, n_arrive);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("run hung, %0d commands still pending", expected_cmds.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
sv/wgtg_pkg.sv
sv/wgtg_seq.sv
sv/waypoint_go_to_goal_controller.sv
sv/wgtg_chk.sv
test/waypoint_go_to_goal_controller_tb.sv
